// ----- design/bcm_pkg.sv -----
package bcm_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int MAX_DIMS_DEF    = 4;
    localparam int COORD_WIDTH_DEF = 24;

    localparam int NUM_RANGES = 4;
    localparam int RANGE_W    = 23;
    localparam int DIMS_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int IDX_W      = 6;
    localparam int CORR_W     = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS   = 3'd4;

    localparam logic [CORR_W-1:0]  ONE_Q16    = 17'd65536;
    localparam logic [CORR_W-1:0]  HALF_Q16   = 17'd32768;
    localparam logic [30:0]        ONE_Q30    = 31'h4000_0000;
    localparam logic [31:0]        PI_Q30     = 32'd3373259426;
    localparam logic [31:0]        INV_PI_Q30 = 32'd341782638;
    localparam logic [RANGE_W-1:0] RANGE_RST  = 23'd65536;
    localparam logic [DIMS_W-1:0]  DIMS_RST   = 3'd1;
    localparam logic [2:0]         LAST_TERM  = 3'd4;

    typedef enum logic [4:0] {
        FAC_IDLE, FAC_DIV_R, FAC_THETA, FAC_X2,
        FAC_SIN_INIT, FAC_SIN_MUL, FAC_SIN_DIV, FAC_SIN_WAIT, FAC_S,
        FAC_COS_INIT, FAC_COS_MUL, FAC_COS_DIV, FAC_COS_WAIT,
        FAC_H, FAC_C, FAC_T1, FAC_T2, FAC_FIN
    } fac_state_t;

    typedef enum logic [2:0] {
        BK_IDLE, BK_WRITE, BK_READ, BK_DIM, BK_FWAIT, BK_ACC, BK_EMIT, BK_DIAG
    } back_state_t;

    // floor(x / k) for x below 2^32: shift out the even part of k, multiply by
    // a rounded-up reciprocal of the odd part, shift the product right
    typedef struct packed {
        logic [1:0]  pre;
        logic [31:0] mul;
        logic [5:0]  post;
    } recip_t;

    // Horner divisors of the sine series, innermost term first:
    // 110, 72, 42, 20, 6
    function automatic recip_t sin_recip(input logic [2:0] k);
        recip_t v;
        unique case (k)
            3'd0:    v = '{2'd1, 32'd2498890064, 6'd37};
            3'd1:    v = '{2'd3, 32'd3817748708, 6'd35};
            3'd2:    v = '{2'd1, 32'd3272356036, 6'd36};
            3'd3:    v = '{2'd2, 32'd3435973837, 6'd34};
            default: v = '{2'd1, 32'd2863311531, 6'd33};
        endcase
        return v;
    endfunction

    // cosine series: 132, 90, 56, 30, 12
    function automatic recip_t cos_recip(input logic [2:0] k);
        recip_t v;
        unique case (k)
            3'd0:    v = '{2'd2, 32'd4164816772, 6'd37};
            3'd1:    v = '{2'd1, 32'd3054198967, 6'd37};
            3'd2:    v = '{2'd3, 32'd2454267027, 6'd34};
            3'd3:    v = '{2'd1, 32'd2290649225, 6'd35};
            default: v = '{2'd2, 32'd2863311531, 6'd33};
        endcase
        return v;
    endfunction

endpackage

// ----- design/bcm_if.sv -----
interface bcm_in_if #(parameter int COORD_WIDTH = bcm_pkg::COORD_WIDTH_DEF);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] coord_0;
    logic signed [COORD_WIDTH-1:0] coord_1;
    logic signed [COORD_WIDTH-1:0] coord_2;
    logic signed [COORD_WIDTH-1:0] coord_3;
    logic                          last_point;

    modport source (output valid, coord_0, coord_1, coord_2, coord_3, last_point,
                    input ready);
    modport sink   (input valid, coord_0, coord_1, coord_2, coord_3, last_point,
                    output ready);
endinterface

interface bcm_out_if;
    logic                        valid;
    logic                        ready;
    logic [bcm_pkg::IDX_W-1:0]   row_index;
    logic [bcm_pkg::IDX_W-1:0]   col_index;
    logic [bcm_pkg::CORR_W-1:0]  correlation;
    logic                        end_of_row;

    modport source (output valid, row_index, col_index, correlation, end_of_row,
                    input ready);
    modport sink   (input valid, row_index, col_index, correlation, end_of_row,
                    output ready);
endinterface

// ----- design/bohman_correlation_matrix_core.sv -----
// Bohman compact-support correlation matrix, built one point per input beat.
//
// points  : input channel, one point per beat (coord_0..coord_3 signed Q7.16,
//           last_point closes the current set).
// entries : output channel, one matrix entry per beat. For new point i the
//           block sends (i, j, corr) for every earlier j of the set, then the
//           diagonal (i, i, 1.0) with end_of_row set.
// cfg_*   : register writes (ranges per dimension, dims_in_use); write only
//           while the block is idle.
//
// A point of row i runs one Bohman factor per dimension in use for each of its
// i earlier points. Each factor runs one radix-2 division for the range ratio,
// then the sine and cosine series terms, each term divided by its constant
// through a reciprocal multiply; equal coordinates or a distance beyond the
// range skip both. A two-deep queue takes the next points while a row is
// worked. Reset clears the point count, the queue and the output register;
// ranges return to 1.0, dims_in_use to 1. When the receiver stalls, the output
// register holds its beat and the back end waits.
module bohman_correlation_matrix_core #(
    parameter int MAX_POINTS  = bcm_pkg::MAX_POINTS_DEF,
    parameter int MAX_DIMS    = bcm_pkg::MAX_DIMS_DEF,
    parameter int COORD_WIDTH = bcm_pkg::COORD_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    bcm_in_if.sink                           points,
    bcm_out_if.source                        entries,
    input  logic                             cfg_we,
    input  logic [bcm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bcm_pkg::RANGE_W-1:0]      cfg_data
);
    import bcm_pkg::*;

    localparam int ROW_W = $clog2(MAX_POINTS);

    logic [NUM_RANGES-1:0][RANGE_W-1:0] range_reg;
    logic [DIMS_W-1:0]                  dims_reg;

    logic                                 q_valid, q_pop;
    logic [ROW_W-1:0]                     q_row;
    logic [MAX_DIMS-1:0][COORD_WIDTH-1:0] q_point;

    // register file; writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_RANGES; i++)
                range_reg[i] <= RANGE_RST;
            dims_reg <= DIMS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RANGE0: range_reg[0] <= cfg_data;
                CFG_RANGE1: range_reg[1] <= cfg_data;
                CFG_RANGE2: range_reg[2] <= cfg_data;
                CFG_RANGE3: range_reg[3] <= cfg_data;
                CFG_DIMS:   dims_reg     <= cfg_data[DIMS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // front: accept, number the point within its set, queue it
    bcm_front #(
        .MAX_POINTS  (MAX_POINTS),
        .MAX_DIMS    (MAX_DIMS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .points  (points),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_row   (q_row),
        .q_point (q_point)
    );

    // back: store the point, walk earlier points, send the row
    bcm_back #(
        .MAX_POINTS  (MAX_POINTS),
        .MAX_DIMS    (MAX_DIMS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_row       (q_row),
        .q_point     (q_point),
        .ranges      (range_reg),
        .dims_in_use (dims_reg),
        .entries     (entries)
    );

endmodule

// ----- design/bcm_div.sv -----
module bcm_div #(
    parameter int NW = 40,
    parameter int DW = 23
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    den_reg;

    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             ge;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        trial = {rem_reg, quo_reg[NW-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = trial >= {1'b0, den_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NW);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- design/bcm_factor.sv -----
module bcm_factor #(
    parameter int COORD_WIDTH = bcm_pkg::COORD_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [COORD_WIDTH-1:0]       span,
    input  logic [bcm_pkg::RANGE_W-1:0]  range_val,
    output logic                         done,
    output logic [bcm_pkg::CORR_W-1:0]   factor
);
    import bcm_pkg::*;

    localparam int NW = COORD_WIDTH + 16;
    localparam int CMP_W = (COORD_WIDTH > RANGE_W) ? COORD_WIDTH : RANGE_W;

    fac_state_t       state_reg, state_next;
    logic             done_reg, done_next;
    logic [CORR_W-1:0] res_reg;
    logic [16:0]      r_reg;
    logic             neg_reg;
    logic [31:0]      theta_reg, x2_reg, s_reg, term1_reg;
    logic [30:0]      t_reg, c_reg;
    logic [2:0]       k_reg;
    logic [63:0]      prod_reg;

    logic [31:0]      mul_a, mul_b;
    logic             div_start, div_done;
    logic [NW-1:0]    div_num, div_quo;
    logic [RANGE_W-1:0] div_den;
    logic             is_zero, is_out;
    logic [16:0]      rp;
    logic [31:0]      h;
    logic [32:0]      fsum;
    logic [18:0]      frnd;
    recip_t           rcp;
    logic [63:0]      quo_c;

    bcm_div #(.NW(NW), .DW(RANGE_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        is_zero = span == '0;
        is_out  = CMP_W'(span) > CMP_W'(range_val);
        rp      = neg_reg ? (ONE_Q16 - r_reg) : r_reg;
        h       = prod_reg[62:31];
        fsum    = neg_reg
                ? ((prod_reg[61:30] > term1_reg) ? {1'b0, prod_reg[61:30] - term1_reg} : '0)
                : ({1'b0, term1_reg} + {1'b0, prod_reg[61:30]});
        frnd    = 19'((fsum + 33'd8192) >> 14);
        rcp     = (state_reg == FAC_COS_DIV || state_reg == FAC_COS_WAIT)
                ? cos_recip(k_reg) : sin_recip(k_reg);
        quo_c   = prod_reg >> rcp.post;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FAC_IDLE:     if (start && !is_zero && !is_out) state_next = FAC_DIV_R;
            FAC_DIV_R:    if (div_done) state_next = FAC_THETA;
            FAC_THETA:    state_next = FAC_X2;
            FAC_X2:       state_next = FAC_SIN_INIT;
            FAC_SIN_INIT: state_next = FAC_SIN_MUL;
            FAC_SIN_MUL:  state_next = FAC_SIN_DIV;
            FAC_SIN_DIV:  state_next = FAC_SIN_WAIT;
            FAC_SIN_WAIT: state_next = (k_reg == LAST_TERM) ? FAC_S : FAC_SIN_MUL;
            FAC_S:        state_next = FAC_COS_INIT;
            FAC_COS_INIT: state_next = FAC_COS_MUL;
            FAC_COS_MUL:  state_next = FAC_COS_DIV;
            FAC_COS_DIV:  state_next = FAC_COS_WAIT;
            FAC_COS_WAIT: state_next = (k_reg == LAST_TERM) ? FAC_H : FAC_COS_MUL;
            FAC_H:        state_next = FAC_C;
            FAC_C:        state_next = FAC_T1;
            FAC_T1:       state_next = FAC_T2;
            FAC_T2:       state_next = FAC_FIN;
            FAC_FIN:      state_next = FAC_IDLE;
            default:      state_next = FAC_IDLE;
        endcase
    end

    // multiplier operands and divider launches
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (state_reg)
            FAC_IDLE:
            begin
                div_start = start && !is_zero && !is_out;
                div_num   = {span, 16'd0};
                div_den   = range_val;
            end
            FAC_THETA:
            begin
                mul_a = 32'(rp);
                mul_b = PI_Q30;
            end
            FAC_X2:
            begin
                mul_a = prod_reg[47:16];
                mul_b = prod_reg[47:16];
            end
            FAC_SIN_MUL, FAC_COS_MUL, FAC_H:
            begin
                mul_a = x2_reg;
                mul_b = {1'b0, t_reg};
            end
            FAC_SIN_DIV, FAC_COS_DIV:
            begin
                mul_a = prod_reg[61:30] >> rcp.pre;
                mul_b = rcp.mul;
            end
            FAC_S:
            begin
                mul_a = theta_reg;
                mul_b = {1'b0, t_reg};
            end
            FAC_T1:
            begin
                mul_a = 32'(ONE_Q16 - r_reg);
                mul_b = {1'b0, c_reg};
            end
            FAC_T2:
            begin
                mul_a = s_reg;
                mul_b = INV_PI_Q30;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    always_comb
    begin
        done_next = 1'b0;
        if (state_reg == FAC_IDLE && start && (is_zero || is_out))
            done_next = 1'b1;
        else if (state_reg == FAC_FIN)
            done_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FAC_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        unique case (state_reg)
            FAC_IDLE:
            begin
                if (start)
                    res_reg <= is_zero ? ONE_Q16 : '0;
            end
            FAC_DIV_R:
            begin
                if (div_done)
                begin
                    r_reg   <= div_quo[16:0];
                    neg_reg <= div_quo[16:0] > HALF_Q16;
                end
            end
            FAC_X2:
                theta_reg <= prod_reg[47:16];
            FAC_SIN_INIT:
            begin
                x2_reg <= prod_reg[61:30];
                t_reg  <= ONE_Q30;
                k_reg  <= '0;
            end
            FAC_SIN_WAIT, FAC_COS_WAIT:
            begin
                t_reg <= ONE_Q30 - quo_c[30:0];
                k_reg <= k_reg + 1'b1;
            end
            FAC_COS_INIT:
            begin
                s_reg <= prod_reg[61:30];
                t_reg <= ONE_Q30;
                k_reg <= '0;
            end
            FAC_C:
                c_reg <= (h >= 32'(ONE_Q30)) ? '0 : 31'(32'(ONE_Q30) - h);
            FAC_T2:
                term1_reg <= prod_reg[47:16];
            FAC_FIN:
                res_reg <= (frnd > 19'(ONE_Q16)) ? ONE_Q16 : frnd[CORR_W-1:0];
            default:
            begin
            end
        endcase
    end

    assign done   = done_reg;
    assign factor = res_reg;

endmodule

// ----- design/bcm_front.sv -----
module bcm_front #(
    parameter int MAX_POINTS  = bcm_pkg::MAX_POINTS_DEF,
    parameter int MAX_DIMS    = bcm_pkg::MAX_DIMS_DEF,
    parameter int COORD_WIDTH = bcm_pkg::COORD_WIDTH_DEF,
    localparam int ROW_W      = $clog2(MAX_POINTS)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    bcm_in_if.sink                               points,
    output logic                                 q_valid,
    input  logic                                 q_pop,
    output logic [ROW_W-1:0]                     q_row,
    output logic [MAX_DIMS-1:0][COORD_WIDTH-1:0] q_point
);
    import bcm_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       fill_reg, fill_next;
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [ROW_W-1:0] row_q_reg [2];
    logic [MAX_DIMS-1:0][COORD_WIDTH-1:0] pt_q_reg [2];

    logic                    push;
    logic [ROW_W-1:0]        row;
    logic [COORD_WIDTH-1:0]  c_in [NUM_RANGES];
    logic [MAX_DIMS-1:0][COORD_WIDTH-1:0] pt;

    assign points.ready = fill_reg != 2'd2;
    assign push         = points.valid && points.ready;

    always_comb
    begin
        c_in[0] = points.coord_0;
        c_in[1] = points.coord_1;
        c_in[2] = points.coord_2;
        c_in[3] = points.coord_3;
        for (int d = 0; d < MAX_DIMS; d++)
            pt[d] = c_in[d];
    end

    // a full store starts a fresh set at row zero
    always_comb
    begin
        row        = (count_reg >= CNT_W'(MAX_POINTS)) ? '0 : count_reg[ROW_W-1:0];
        count_next = count_reg;
        if (push)
            count_next = points.last_point ? '0 : CNT_W'(row) + 1'b1;
        fill_next = fill_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            fill_reg   <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            fill_reg  <= fill_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            row_q_reg[wr_ptr_reg] <= row;
            pt_q_reg[wr_ptr_reg]  <= pt;
        end
    end

    assign q_valid = fill_reg != 2'd0;
    assign q_row   = row_q_reg[rd_ptr_reg];
    assign q_point = pt_q_reg[rd_ptr_reg];

endmodule

// ----- design/bcm_back.sv -----
module bcm_back #(
    parameter int MAX_POINTS  = bcm_pkg::MAX_POINTS_DEF,
    parameter int MAX_DIMS    = bcm_pkg::MAX_DIMS_DEF,
    parameter int COORD_WIDTH = bcm_pkg::COORD_WIDTH_DEF,
    localparam int ROW_W      = $clog2(MAX_POINTS)
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                q_valid,
    output logic                                                q_pop,
    input  logic [ROW_W-1:0]                                    q_row,
    input  logic [MAX_DIMS-1:0][COORD_WIDTH-1:0]                q_point,
    input  logic [bcm_pkg::NUM_RANGES-1:0][bcm_pkg::RANGE_W-1:0] ranges,
    input  logic [bcm_pkg::DIMS_W-1:0]                          dims_in_use,
    bcm_out_if.source                                           entries
);
    import bcm_pkg::*;

    localparam int LANE_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam logic [DIMS_W-1:0] DIMS_MAX = DIMS_W'(MAX_DIMS);

    back_state_t      state_reg, state_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] j_reg;
    logic [DIMS_W-1:0] k_reg;
    logic [CORR_W-1:0] acc_reg;
    logic [33:0]      accprod_reg;
    logic [MAX_DIMS-1:0][COORD_WIDTH-1:0] cur_reg, rd_reg;
    logic [MAX_DIMS-1:0][COORD_WIDTH-1:0] store_mem [MAX_POINTS];

    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_row_reg, out_col_reg;
    logic [CORR_W-1:0] out_corr_reg;
    logic              out_eor_reg;

    logic [DIMS_W-1:0]       dims;
    logic                    slot_free;
    logic                    load_entry, load_diag;
    logic                    fac_start, fac_done;
    logic [CORR_W-1:0]       fac_val;
    logic [COORD_WIDTH:0]    diff;
    logic [COORD_WIDTH-1:0]  span;

    bcm_factor #(.COORD_WIDTH(COORD_WIDTH)) u_factor (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (fac_start),
        .span      (span),
        .range_val (ranges[k_reg[1:0]]),
        .done      (fac_done),
        .factor    (fac_val)
    );

    always_comb
    begin
        dims      = (dims_in_use > DIMS_MAX) ? DIMS_MAX : dims_in_use;
        slot_free = !out_valid_reg || entries.ready;
        diff      = {cur_reg[k_reg[LANE_W-1:0]][COORD_WIDTH-1], cur_reg[k_reg[LANE_W-1:0]]}
                  - {rd_reg[k_reg[LANE_W-1:0]][COORD_WIDTH-1], rd_reg[k_reg[LANE_W-1:0]]};
        span      = diff[COORD_WIDTH] ? COORD_WIDTH'(-diff) : diff[COORD_WIDTH-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:  if (q_valid) state_next = BK_WRITE;
            BK_WRITE: state_next = (row_reg == '0) ? BK_DIAG : BK_READ;
            BK_READ:  state_next = BK_DIM;
            BK_DIM:   state_next = (k_reg < dims) ? BK_FWAIT : BK_EMIT;
            BK_FWAIT: if (fac_done) state_next = BK_ACC;
            BK_ACC:   state_next = BK_DIM;
            BK_EMIT:
            begin
                if (slot_free)
                    state_next = (j_reg == row_reg - 1'b1) ? BK_DIAG : BK_READ;
            end
            BK_DIAG:  if (slot_free) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop      = state_reg == BK_IDLE && q_valid;
        fac_start  = state_reg == BK_DIM && k_reg < dims;
        load_entry = state_reg == BK_EMIT && slot_free;
        load_diag  = state_reg == BK_DIAG && slot_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_entry || load_diag)
                out_valid_reg <= 1'b1;
            else if (entries.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_WRITE)
            store_mem[row_reg] <= cur_reg;
        if (state_reg == BK_READ)
            rd_reg <= store_mem[j_reg];
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                row_reg <= q_row;
                cur_reg <= q_point;
                j_reg   <= '0;
            end
            BK_READ:
            begin
                k_reg   <= '0;
                acc_reg <= ONE_Q16;
            end
            BK_FWAIT:
                accprod_reg <= acc_reg * fac_val;
            BK_ACC:
            begin
                acc_reg <= CORR_W'((accprod_reg + 34'(HALF_Q16)) >> 16);
                k_reg   <= k_reg + 1'b1;
            end
            BK_EMIT:
                if (slot_free)
                    j_reg <= j_reg + 1'b1;
            default:
            begin
            end
        endcase

        if (load_entry)
        begin
            out_row_reg  <= IDX_W'(row_reg);
            out_col_reg  <= IDX_W'(j_reg);
            out_corr_reg <= acc_reg;
            out_eor_reg  <= 1'b0;
        end
        else if (load_diag)
        begin
            out_row_reg  <= IDX_W'(row_reg);
            out_col_reg  <= IDX_W'(row_reg);
            out_corr_reg <= ONE_Q16;
            out_eor_reg  <= 1'b1;
        end
    end

    assign entries.valid       = out_valid_reg;
    assign entries.row_index   = out_row_reg;
    assign entries.col_index   = out_col_reg;
    assign entries.correlation = out_corr_reg;
    assign entries.end_of_row  = out_eor_reg;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import bcm_pkg::*;

    localparam int CW        = COORD_WIDTH_DEF;
    localparam int NPTS      = MAX_POINTS_DEF;
    localparam int NDIM      = MAX_DIMS_DEF;
    localparam int RAND_GOAL = 60;
    localparam int DRAIN     = 60;
    localparam int HOLD_LEN  = 3000;
    localparam longint CYCLE_LIMIT = 12_000_000;

    typedef struct packed {
        logic [NDIM-1:0][CW-1:0] coord;
        logic                    last;
    } point_t;

    typedef struct packed {
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [CORR_W-1:0] corr;
        logic              eor;
    } entry_t;

    // Directed row: a point, and where it is plain to see, the value of the
    // single off-diagonal entry (column 0) that it produces.
    typedef struct packed {
        point_t pt;
        int     col0_corr;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_RANGE0;
    logic [RANGE_W-1:0]   cfg_data = '0;

    bcm_in_if #(.COORD_WIDTH(CW)) points ();
    bcm_out_if entries ();

    bohman_correlation_matrix_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .points    (points.sink),
        .entries   (entries.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Shadow of the block: configuration, the stored points of the open set,
    // and the queue of matrix entries still owed by the block.
    logic [RANGE_W-1:0]      support_range [NDIM];
    logic [DIMS_W-1:0]       dims_used;
    logic [NDIM-1:0][CW-1:0] held_points [NPTS];
    int                      held_count;
    entry_t                  owed_entries [$];

    int     errors = 0;
    longint cycles = 0;
    logic   calm = 1'b0;       // no idling on either side while set
    logic   hold_req = 1'b0;
    int     hold_left = 0;
    int     rand_items = 0;

    initial
    begin
        points.valid      = 1'b0;
        points.coord_0    = '0;
        points.coord_1    = '0;
        points.coord_2    = '0;
        points.coord_3    = '0;
        points.last_point = 1'b0;
        entries.ready     = 1'b0;
        for (int k = 0; k < NDIM; k++)
            support_range[k] = RANGE_RST;
        dims_used  = DIMS_RST;
        held_count = 0;
    end

    // Bound the run; a hang anywhere ends up here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report(input string what, input entry_t got, input entry_t want);
        errors++;
        $display("mismatch %s: got row %0d col %0d corr %0d eor %0d, want row %0d col %0d corr %0d eor %0d",
                 what, got.row, got.col, got.corr, got.eor,
                 want.row, want.col, want.corr, want.eor);
    endtask

    // One Bohman factor in Q1.16 for a distance and a support range.
    function automatic longint unsigned bohman_weight(input longint unsigned span,
                                                      input longint unsigned rng);
        longint unsigned sdiv [5] = '{110, 72, 42, 20, 6};
        longint unsigned cdiv [5] = '{132, 90, 56, 30, 12};
        longint unsigned one = longint'(ONE_Q30);
        longint unsigned r, rp, theta, x2, t, s, c, h, t1, t2, f;
        bit neg;
        if (span == 0)
            return 65536;
        if (span > rng)
            return 0;
        r     = (span << 16) / rng;
        neg   = r > 32768;
        rp    = neg ? 65536 - r : r;
        theta = (rp * longint'(PI_Q30)) >> 16;
        x2    = (theta * theta) >> 30;
        t = one;
        for (int k = 0; k < 5; k++)
            t = one - ((x2 * t) >> 30) / sdiv[k];
        s = (theta * t) >> 30;
        t = one;
        for (int k = 0; k < 5; k++)
            t = one - ((x2 * t) >> 30) / cdiv[k];
        h  = ((x2 * t) >> 30) / 2;
        c  = (h >= one) ? 0 : one - h;
        t1 = ((65536 - r) * c) >> 16;
        t2 = (s * longint'(INV_PI_Q30)) >> 30;
        if (neg)
            f = (t2 > t1) ? t2 - t1 : 0;
        else
            f = t1 + t2;
        f = (f + 8192) >> 14;
        return (f > 65536) ? 65536 : f;
    endfunction

    // Store an accepted point and queue the row of entries it owes.
    task automatic predict_row(input point_t pt, input int col0_corr);
        int row, dims;
        longint signed a, b, diff;
        longint unsigned acc;
        entry_t e;
        if (held_count >= NPTS)
            held_count = 0;
        row = held_count;
        held_points[row] = pt.coord;
        dims = (dims_used > NDIM) ? NDIM : dims_used;
        for (int j = 0; j < row; j++)
        begin
            acc = 65536;
            for (int k = 0; k < dims; k++)
            begin
                a    = longint'($signed(held_points[row][k]));
                b    = longint'($signed(held_points[j][k]));
                diff = a - b;
                acc  = (acc * bohman_weight(diff < 0 ? -diff : diff,
                                            support_range[k]) + 32768) >> 16;
            end
            e.row  = row[IDX_W-1:0];
            e.col  = j[IDX_W-1:0];
            e.corr = (j == 0 && col0_corr >= 0) ? col0_corr[CORR_W-1:0] : acc[CORR_W-1:0];
            e.eor  = 1'b0;
            owed_entries.push_back(e);
        end
        e.row  = row[IDX_W-1:0];
        e.col  = row[IDX_W-1:0];
        e.corr = ONE_Q16;
        e.eor  = 1'b1;
        owed_entries.push_back(e);
        held_count = pt.last ? 0 : row + 1;
    endtask

    // Offer one point; idle first at random, hold it until the block takes it.
    task automatic send_point(input point_t pt, input int col0_corr);
        while (!calm && $urandom_range(0, 99) < 27)
        begin
            points.valid <= 1'b0;
            @(posedge clk);
        end
        points.valid      <= 1'b1;
        points.coord_0    <= pt.coord[0];
        points.coord_1    <= pt.coord[1];
        points.coord_2    <= pt.coord[2];
        points.coord_3    <= pt.coord[3];
        points.last_point <= pt.last;
        do
            @(posedge clk);
        while (!points.ready);
        predict_row(pt, col0_corr);
    endtask

    task automatic wait_idle();
        points.valid <= 1'b0;
        while (owed_entries.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    // Write every register; only called with the block idle.
    task automatic write_config(input logic [RANGE_W-1:0] r0, input logic [RANGE_W-1:0] r1,
                                input logic [RANGE_W-1:0] r2, input logic [RANGE_W-1:0] r3,
                                input logic [DIMS_W-1:0] dims);
        logic [RANGE_W-1:0] vals [NUM_RANGES];
        vals = '{r0, r1, r2, r3};
        for (int k = 0; k < NUM_RANGES; k++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_RANGE0 + k[CFG_IDX_W-1:0];
            cfg_data  <= vals[k];
            support_range[k] = vals[k];
            @(posedge clk);
        end
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DIMS;
        cfg_data  <= RANGE_W'(dims);
        dims_used = dims;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Pick a coordinate near the base: equal, inside the support, or anywhere.
    function automatic logic [CW-1:0] near_coord(input logic [CW-1:0] base,
                                                 input logic [RANGE_W-1:0] rng);
        int pick;
        logic [CW-1:0] off;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            return base;
        if (pick < 70)
        begin
            off = CW'($urandom_range(0, rng));
            return $urandom_range(0, 1) ? base + off : base - off;
        end
        return CW'($urandom());
    endfunction

    task automatic send_set(input int len, input bit counted);
        point_t pt;
        logic [NDIM-1:0][CW-1:0] base;
        for (int k = 0; k < NDIM; k++)
            base[k] = CW'($urandom());
        for (int i = 0; i < len; i++)
        begin
            for (int k = 0; k < NDIM; k++)
                pt.coord[k] = near_coord(base[k], support_range[k]);
            pt.last = (i == len - 1);
            send_point(pt, -1);
            if (counted)
                rand_items++;
        end
    endtask

    // Hold-off counter for the pressure test: ready stays low while it runs.
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_req)
        begin
            hold_left <= HOLD_LEN;
            hold_req  <= 1'b0;
        end
    end

    // Receiver: check each beat against the oldest owed entry, then choose ready.
    always @(posedge clk)
    begin
        entry_t got, want;
        if (rst_n && entries.valid && entries.ready)
        begin
            got = '{entries.row_index, entries.col_index, entries.correlation,
                    entries.end_of_row};
            if (owed_entries.size() == 0)
                report("unexpected beat", got, got);
            else
            begin
                want = owed_entries.pop_front();
                if (got.row !== want.row)
                    report("row_index", got, want);
                else if (got.col !== want.col)
                    report("col_index", got, want);
                else if (got.corr !== want.corr)
                    report("correlation", got, want);
                else if (got.eor !== want.eor)
                    report("end_of_row", got, want);
            end
        end
        if (hold_left > 0 || hold_req)
            entries.ready <= 1'b0;
        else
            entries.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 27);
    end

    // Directed points under the reset configuration (range 1.0, one dimension).
    // Most sets are two points long so that column 0 is the only off-diagonal
    // entry.
    stim_row_t directed [] = '{
        '{'{{24'h0, 24'h0, 24'h0, 24'h000000}, 1'b0}, -1},
        '{'{{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h000000}, 1'b1}, 65536},  // equal
        '{'{{24'h0, 24'h0, 24'h0, 24'h000000}, 1'b0}, -1},
        '{'{{24'h0, 24'h0, 24'h0, 24'h010000}, 1'b1}, 0},       // distance at range
        '{'{{24'hFFFFFF, 24'h800000, 24'h7FFFFF, 24'h800000}, 1'b0}, -1},
        '{'{{24'h800000, 24'h7FFFFF, 24'h0, 24'h7FFFFF}, 1'b1}, 0},  // far apart
        '{'{{24'h0, 24'h0, 24'h0, 24'h000000}, 1'b0}, -1},
        '{'{{24'h0, 24'h0, 24'h0, 24'h008000}, 1'b1}, -1},      // half the range
        '{'{{24'h0, 24'h0, 24'h0, 24'hFF4000}, 1'b0}, -1},
        '{'{{24'h0, 24'h0, 24'h0, 24'h000000}, 1'b1}, -1},      // beyond half
        '{'{{24'h123456, 24'h0, 24'h0, 24'h003039}, 1'b0}, -1},
        '{'{{24'h0, 24'h654321, 24'h0, 24'h00303A}, 1'b0}, -1}, // one step away
        '{'{{24'h0, 24'h0, 24'hABCDEF, 24'hFFD000}, 1'b1}, -1},
        '{'{{24'h0, 24'h0, 24'h0, 24'h000001}, 1'b1}, -1}       // lone point
    };

    initial
    begin
        point_t pt;
        logic [RANGE_W-1:0] rr [NUM_RANGES];
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration and the directed table.
        foreach (directed[i])
            send_point(directed[i].pt, directed[i].col0_corr);
        wait_idle();

        // Range extremes, zero range among them, all four dimensions.
        write_config(23'd0, 23'h7FFFFF, 23'd1, 23'd65536, 3'd4);
        for (int s = 0; s < 4; s++)
            send_set($urandom_range(2, 4), 1'b0);
        wait_idle();

        // No dimensions: every entry is 1.0, so the rows run fast. Fill the
        // store past its end, and hold the receiver off meanwhile so the
        // block backs up into its input.
        write_config(23'h7FFFFF, 23'd0, 23'h2AAAAA, 23'h555555, 3'd0);
        hold_req <= 1'b1;
        for (int i = 0; i < NPTS + 3; i++)
        begin
            for (int k = 0; k < NDIM; k++)
                pt.coord[k] = CW'($urandom());
            pt.last = 1'b0;
            send_point(pt, -1);
        end
        wait_idle();

        // Too many dimensions saturate to four.
        write_config(23'd65536, 23'd131072, 23'd32768, 23'd262144, 3'd7);
        send_set(3, 1'b0);
        wait_idle();
        write_config(23'd200000, 23'd100000, 23'd50000, 23'd400000, 3'd5);
        send_set(3, 1'b0);
        wait_idle();

        // Random phases: fresh configuration, then a few sets of random length.
        for (int ph = 0; rand_items < RAND_GOAL; ph++)
        begin
            for (int k = 0; k < NUM_RANGES; k++)
                case ($urandom_range(0, 9))
                    0:       rr[k] = RANGE_W'($urandom());
                    1:       rr[k] = 23'h7FFFFF;
                    default: rr[k] = RANGE_W'($urandom_range(1024, 600000));
                endcase
            write_config(rr[0], rr[1], rr[2], rr[3], DIMS_W'($urandom_range(1, 4)));
            calm <= (ph == 1);
            for (int s = $urandom_range(2, 4); s > 0; s--)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // Noise: a point far from anything, closing its own set.
                    for (int k = 0; k < NDIM; k++)
                        pt.coord[k] = CW'($urandom());
                    pt.last = 1'b1;
                    send_point(pt, -1);
                    rand_items++;
                end
                else
                    send_set($urandom_range(1, 8), 1'b1);
            end
            wait_idle();
        end

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
design/bcm_pkg.sv
design/bcm_if.sv
design/bcm_div.sv
design/bcm_factor.sv
design/bcm_front.sv
design/bcm_back.sv
design/bohman_correlation_matrix_core.sv
sim/tb_top.sv
